/* rtl/pest_pkg.sv */
// Shared types and constants of the polyline equal-spacing trigger block.
`default_nettype none
package pest_pkg;

    localparam int MAX_TRIG_DEFAULT  = 64;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic [31:0] SPACING_RESET = 32'd65536;
    localparam logic [15:0] PULSE_RESET   = 16'd2000;
    localparam logic [47:0] DIST_MAX      = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] IDX_MAX       = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CFG_SPACING = 2'd0,
        CFG_PULSE   = 2'd1
    } t_cfg_idx;

    // One classified vertex: either a path restart or a segment to walk.
    typedef struct packed {
        logic               restart;
        logic        [31:0] base_x;
        logic        [31:0] base_y;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } t_seg;

endpackage
`default_nettype wire

/* rtl/pest_front.sv */
// Front end: accepts vertices, classifies them and forms the segment deltas.
`default_nettype none
module pest_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic  [31:0] i_vertex_x,
    input  wire logic  [31:0] i_vertex_y,
    input  wire logic         i_path_start,
    input  wire logic         i_q_full,
    output logic              o_push,
    output pest_pkg::t_seg    o_seg
);

    logic        r_have_prev, n_have_prev;
    logic [31:0] r_prev_x, n_prev_x;
    logic [31:0] r_prev_y, n_prev_y;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_seg.restart = i_path_start || !r_have_prev;
        o_seg.base_x  = r_prev_x;
        o_seg.base_y  = r_prev_y;
        o_seg.dx      = $signed({i_vertex_x[31], i_vertex_x}) - $signed({r_prev_x[31], r_prev_x});
        o_seg.dy      = $signed({i_vertex_y[31], i_vertex_y}) - $signed({r_prev_y[31], r_prev_y});
    end

    always_comb begin
        n_have_prev = r_have_prev;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        if (o_push) begin
            n_have_prev = 1'b1;
            n_prev_x    = i_vertex_x;
            n_prev_y    = i_vertex_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else begin
            r_have_prev <= n_have_prev;
        end
        r_prev_x <= n_prev_x;
        r_prev_y <= n_prev_y;
    end

endmodule
`default_nettype wire

/* rtl/pest_queue.sv */
// Two-entry queue between the front and back ends.
`default_nettype none
module pest_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

/* rtl/pest_back.sv */
// Back end: segment length, trigger placement, interpolation and result output.
`default_nettype none
module pest_back #(
    parameter int MAX_TRIG  = pest_pkg::MAX_TRIG_DEFAULT,
    parameter int FRAC_BITS = pest_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_valid,
    input  pest_pkg::t_seg    i_q_data,
    output logic              o_q_pop,
    input  wire logic  [31:0] i_spacing,
    input  wire logic  [15:0] i_pulse_width,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic       [31:0] o_trigger_x,
    output logic       [31:0] o_trigger_y,
    output logic       [47:0] o_arc_length,
    output logic       [31:0] o_sequence_number,
    output logic       [15:0] o_pulse_out,
    output logic              o_last_in_run,
    output logic              o_overflow
);

    localparam int NW = $clog2(MAX_TRIG + 1);
    localparam int RW = FRAC_BITS + 1;
    localparam logic [NW-1:0] N_MAX    = NW'(MAX_TRIG);
    localparam logic [65:0]   RND      = 66'd1 << (FRAC_BITS - 1);
    localparam logic [5:0]    DIV_LAST = 6'(FRAC_BITS);

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_SQX  = 16'h0002,
        S_SQY  = 16'h0004,
        S_ADD  = 16'h0008,
        S_SQRT = 16'h0010,
        S_ENDC = 16'h0020,
        S_OVF  = 16'h0040,
        S_OVF2 = 16'h0080,
        S_TGT  = 16'h0100,
        S_CHK  = 16'h0200,
        S_DIV  = 16'h0400,
        S_MX   = 16'h0800,
        S_MY   = 16'h1000,
        S_RES  = 16'h2000,
        S_FIN  = 16'h4000,
        S_SKIP = 16'h8000
    } t_state;

    t_state             r_state, n_state;
    logic        [5:0]  r_cnt, n_cnt;
    logic        [31:0] r_base_x, n_base_x;
    logic        [31:0] r_base_y, n_base_y;
    logic signed [32:0] r_dx, n_dx;
    logic signed [32:0] r_dy, n_dy;
    logic        [65:0] r_prod;
    logic        [65:0] r_acc, n_acc;
    logic        [32:0] r_root, n_root;
    logic        [35:0] r_rem, n_rem;
    logic        [32:0] r_len, n_len;
    logic        [47:0] r_end, n_end;
    logic        [47:0] r_trav, n_trav;
    logic        [31:0] r_next, n_next;
    logic      [NW-1:0] r_n, n_n;
    logic               r_ovf, n_ovf;
    logic      [RW-1:0] r_ratio, n_ratio;
    logic        [47:0] r_tgt, n_tgt;
    logic        [31:0] r_res_x, n_res_x;
    logic               r_pend_v, n_pend_v;
    logic        [31:0] r_pend_x, n_pend_x;
    logic        [31:0] r_pend_y, n_pend_y;
    logic        [47:0] r_pend_dist, n_pend_dist;
    logic        [31:0] r_pend_seq, n_pend_seq;
    logic               r_out_v, n_out_v;
    logic        [31:0] r_out_x, n_out_x;
    logic        [31:0] r_out_y, n_out_y;
    logic        [47:0] r_out_dist, n_out_dist;
    logic        [31:0] r_out_seq, n_out_seq;
    logic        [15:0] r_out_pulse, n_out_pulse;
    logic               r_out_last, n_out_last;
    logic               r_out_ovf, n_out_ovf;

    logic [32:0] w_mag_x, w_mag_y, w_ma, w_mb;
    logic [65:0] w_prod;
    logic [35:0] w_rem2, w_trial;
    logic        w_sq_ge;
    logic [48:0] w_sum;
    logic [47:0] w_end;
    logic [32:0] w_nm;
    logic [47:0] w_off;
    logic        w_div_ge;
    logic [35:0] w_div_rem;
    logic [65:0] w_rnd;
    logic [31:0] w_q32, w_coord;
    logic [32:0] w_srem2;
    logic        w_sge;
    logic [47:0] w_quot;
    logic [31:0] w_skip;
    logic        w_out_free;

    assign w_mag_x = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign w_mag_y = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);

    // One shared multiplier; its operands follow the state.
    always_comb begin
        case (r_state)
            S_SQX: begin
                w_ma = w_mag_x;
                w_mb = w_mag_x;
            end
            S_SQY: begin
                w_ma = w_mag_y;
                w_mb = w_mag_y;
            end
            S_OVF: begin
                w_ma = w_nm;
                w_mb = {1'b0, i_spacing};
            end
            S_TGT: begin
                w_ma = {1'b0, r_next};
                w_mb = {1'b0, i_spacing};
            end
            S_MX: begin
                w_ma = w_mag_x;
                w_mb = 33'(r_ratio);
            end
            S_MY, S_RES: begin
                w_ma = w_mag_y;
                w_mb = 33'(r_ratio);
            end
            default: begin
                w_ma = 33'd0;
                w_mb = 33'd0;
            end
        endcase
    end

    assign w_prod = 66'(w_ma) * 66'(w_mb);

    assign w_rem2  = {r_rem[33:0], r_acc[65:64]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_sq_ge = (w_rem2 >= w_trial);

    assign w_sum = {1'b0, r_trav} + 49'(r_root);
    assign w_end = w_sum[48] ? pest_pkg::DIST_MAX : w_sum[47:0];
    assign w_nm  = {1'b0, r_next} + 33'(MAX_TRIG);

    // A target behind the segment start (spacing changed mid-path) sits at the start.
    assign w_off = (r_prod[47:0] > r_trav) ? (r_prod[47:0] - r_trav) : 48'd0;

    assign w_div_ge  = (r_rem >= {3'b000, r_len});
    assign w_div_rem = w_div_ge ? (r_rem - {3'b000, r_len}) : r_rem;

    assign w_rnd   = r_prod + RND;
    assign w_q32   = w_rnd[FRAC_BITS +: 32];

    assign w_srem2 = {r_rem[31:0], r_acc[47]};
    assign w_sge   = (w_srem2 >= {1'b0, i_spacing});
    assign w_quot  = {r_acc[46:0], w_sge};
    assign w_skip  = ((w_quot[47:32] != 16'd0) || (w_quot[31:0] == pest_pkg::IDX_MAX)) ?
                     pest_pkg::IDX_MAX : (w_quot[31:0] + 32'd1);

    assign w_out_free = !r_out_v || !i_out_stall;

    always_comb begin
        if (r_state == S_MY) begin
            w_coord = r_dx[32] ? (r_base_x - w_q32) : (r_base_x + w_q32);
        end else begin
            w_coord = r_dy[32] ? (r_base_y - w_q32) : (r_base_y + w_q32);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_base_x    = r_base_x;
        n_base_y    = r_base_y;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_acc       = r_acc;
        n_root      = r_root;
        n_rem       = r_rem;
        n_len       = r_len;
        n_end       = r_end;
        n_trav      = r_trav;
        n_next      = r_next;
        n_n         = r_n;
        n_ovf       = r_ovf;
        n_ratio     = r_ratio;
        n_tgt       = r_tgt;
        n_res_x     = r_res_x;
        n_pend_v    = r_pend_v;
        n_pend_x    = r_pend_x;
        n_pend_y    = r_pend_y;
        n_pend_dist = r_pend_dist;
        n_pend_seq  = r_pend_seq;
        n_out_v     = r_out_v && i_out_stall;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_dist  = r_out_dist;
        n_out_seq   = r_out_seq;
        n_out_pulse = r_out_pulse;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        o_q_pop     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.restart) begin
                        n_trav = 48'd0;
                        n_next = 32'd1;
                    end else begin
                        n_base_x = i_q_data.base_x;
                        n_base_y = i_q_data.base_y;
                        n_dx     = i_q_data.dx;
                        n_dy     = i_q_data.dy;
                        n_state  = S_SQX;
                    end
                end
            end
            S_SQX: begin
                n_state = S_SQY;
            end
            S_SQY: begin
                n_acc   = r_prod;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_acc   = r_acc + r_prod;
                n_root  = 33'd0;
                n_rem   = 36'd0;
                n_cnt   = 6'd32;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                // Two radicand bits per step, one root bit out.
                n_rem  = w_sq_ge ? (w_rem2 - w_trial) : w_rem2;
                n_root = {r_root[31:0], w_sq_ge};
                n_acc  = {r_acc[63:0], 2'b00};
                if (r_cnt == 6'd0) begin
                    n_state = S_ENDC;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_ENDC: begin
                n_len = r_root;
                n_end = w_end;
                if ((r_root == 33'd0) || (i_spacing == 32'd0)) begin
                    n_trav  = w_end;
                    n_state = S_IDLE;
                end else begin
                    n_n      = '0;
                    n_pend_v = 1'b0;
                    n_state  = S_OVF;
                end
            end
            S_OVF: begin
                n_state = S_OVF2;
            end
            S_OVF2: begin
                // Overflow is known up front: the trigger just past the limit still fits.
                n_ovf   = (w_nm < {1'b0, pest_pkg::IDX_MAX}) && (r_prod <= {18'd0, r_end});
                n_state = S_TGT;
            end
            S_TGT: begin
                if ((r_n == N_MAX) || (r_next == pest_pkg::IDX_MAX)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_prod > {18'd0, r_end}) begin
                    n_state = S_FIN;
                end else begin
                    n_tgt   = r_prod[47:0];
                    n_rem   = {3'b000, w_off[32:0]};
                    n_ratio = '0;
                    n_cnt   = DIV_LAST;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem   = {w_div_rem[34:0], 1'b0};
                n_ratio = {r_ratio[RW-2:0], w_div_ge};
                if (r_cnt == 6'd0) begin
                    n_state = S_MX;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_MX: begin
                n_state = S_MY;
            end
            S_MY: begin
                n_res_x = w_coord;
                n_state = S_RES;
            end
            S_RES: begin
                // The previous trigger leaves only once it is known not to be the last.
                if (!r_pend_v || w_out_free) begin
                    if (r_pend_v) begin
                        n_out_v     = 1'b1;
                        n_out_x     = r_pend_x;
                        n_out_y     = r_pend_y;
                        n_out_dist  = r_pend_dist;
                        n_out_seq   = r_pend_seq;
                        n_out_pulse = i_pulse_width;
                        n_out_last  = 1'b0;
                        n_out_ovf   = r_ovf;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_x    = r_res_x;
                    n_pend_y    = w_coord;
                    n_pend_dist = r_tgt;
                    n_pend_seq  = r_next;
                    n_next      = r_next + 32'd1;
                    n_n         = r_n + NW'(1);
                    n_state     = S_TGT;
                end
            end
            S_FIN: begin
                if (!r_pend_v || w_out_free) begin
                    if (r_pend_v) begin
                        n_out_v     = 1'b1;
                        n_out_x     = r_pend_x;
                        n_out_y     = r_pend_y;
                        n_out_dist  = r_pend_dist;
                        n_out_seq   = r_pend_seq;
                        n_out_pulse = i_pulse_width;
                        n_out_last  = 1'b1;
                        n_out_ovf   = r_ovf;
                        n_pend_v    = 1'b0;
                    end
                    n_trav = r_end;
                    if (r_ovf) begin
                        n_acc   = {18'd0, r_end};
                        n_rem   = 36'd0;
                        n_cnt   = 6'd47;
                        n_state = S_SKIP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SKIP: begin
                // Restoring division of the segment end by the spacing, one bit a cycle.
                n_rem = {3'b000, (w_sge ? (w_srem2 - {1'b0, i_spacing}) : w_srem2)};
                n_acc = {18'd0, w_quot};
                if (r_cnt == 6'd0) begin
                    n_next  = w_skip;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_trav   <= 48'd0;
            r_next   <= 32'd1;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_n      <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_trav   <= n_trav;
            r_next   <= n_next;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            r_n      <= n_n;
            r_ovf    <= n_ovf;
        end
        r_cnt       <= n_cnt;
        r_base_x    <= n_base_x;
        r_base_y    <= n_base_y;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_prod      <= w_prod;
        r_acc       <= n_acc;
        r_root      <= n_root;
        r_rem       <= n_rem;
        r_len       <= n_len;
        r_end       <= n_end;
        r_ratio     <= n_ratio;
        r_tgt       <= n_tgt;
        r_res_x     <= n_res_x;
        r_pend_x    <= n_pend_x;
        r_pend_y    <= n_pend_y;
        r_pend_dist <= n_pend_dist;
        r_pend_seq  <= n_pend_seq;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_dist  <= n_out_dist;
        r_out_seq   <= n_out_seq;
        r_out_pulse <= n_out_pulse;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid       = r_out_v;
    assign o_trigger_x       = r_out_x;
    assign o_trigger_y       = r_out_y;
    assign o_arc_length      = r_out_dist;
    assign o_sequence_number = r_out_seq;
    assign o_pulse_out       = r_out_pulse;
    assign o_last_in_run     = r_out_last;
    assign o_overflow        = r_out_ovf;

endmodule
`default_nettype wire

/* rtl/polyline_equal_spacing_triggers.sv */
// Top level of the polyline equal-spacing trigger block.
// Vertices arrive one word at a time; each non-restart vertex closes a segment on which
// triggers are placed at whole multiples of the spacing register. A segment is worked
// through the squares and the 33-step square root, then the bit-serial ratio divider for
// each trigger, and the bit-serial skip divider when the segment overflows. A two-word
// queue lets the next vertices be accepted while the back end works, and a registered
// output word lets a result wait without stopping the back end's next calculation.
`default_nettype none
module polyline_equal_spacing_triggers #(
    parameter int MAX_TRIGGERS_PER_SEGMENT = pest_pkg::MAX_TRIG_DEFAULT,
    parameter int FRACTION_BITS            = pest_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_vertex_x,
    input  wire logic [31:0] i_vertex_y,
    input  wire logic        i_path_start,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_trigger_x,
    output logic      [31:0] o_trigger_y,
    output logic      [47:0] o_arc_length,
    output logic      [31:0] o_sequence_number,
    output logic      [15:0] o_pulse_out,
    output logic             o_last_in_run,
    output logic             o_overflow,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int SEG_W = $bits(pest_pkg::t_seg);

    logic [31:0]    r_spacing, n_spacing;
    logic [15:0]    r_pulse, n_pulse;
    logic           w_push, w_full, w_q_valid, w_pop;
    pest_pkg::t_seg w_seg_in, w_seg_out;
    logic [SEG_W-1:0] w_rdata;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_spacing = r_spacing;
        n_pulse   = r_pulse;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                pest_pkg::CFG_SPACING: n_spacing = i_cfg_data;
                pest_pkg::CFG_PULSE:   n_pulse   = i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= pest_pkg::SPACING_RESET;
            r_pulse   <= pest_pkg::PULSE_RESET;
        end else begin
            r_spacing <= n_spacing;
            r_pulse   <= n_pulse;
        end
    end

    pest_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_vertex_x   (i_vertex_x),
        .i_vertex_y   (i_vertex_y),
        .i_path_start (i_path_start),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_seg        (w_seg_in)
    );

    pest_queue #(
        .WIDTH (SEG_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_seg_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_rdata (w_rdata)
    );

    assign w_seg_out = w_rdata;

    pest_back #(
        .MAX_TRIG  (MAX_TRIGGERS_PER_SEGMENT),
        .FRAC_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_q_data          (w_seg_out),
        .o_q_pop           (w_pop),
        .i_spacing         (r_spacing),
        .i_pulse_width     (r_pulse),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_trigger_x       (o_trigger_x),
        .o_trigger_y       (o_trigger_y),
        .o_arc_length      (o_arc_length),
        .o_sequence_number (o_sequence_number),
        .o_pulse_out       (o_pulse_out),
        .o_last_in_run     (o_last_in_run),
        .o_overflow        (o_overflow)
    );

    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue written while full");

    a_no_pop_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue read while empty");

    a_seq_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sequence_number != 32'd0))
        else $error("trigger word with sequence number zero");

    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

endmodule
`default_nettype wire
